// ----- rtl/bpa_pkg.sv -----
// shared types and constants for the bitmap page allocator
package bpa_pkg;

    localparam int MAX_PAGES = 4096;
    localparam int PAGE_W    = 12;
    localparam int COUNT_W   = 13;
    localparam int WORD_BITS = 64;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int ROWS      = MAX_PAGES / WORD_BITS;
    localparam int ROW_W     = $clog2(ROWS);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [PAGE_W-1:0]  page_index;
        logic [COUNT_W-1:0] page_count;
    } in_beat_t;

    typedef struct packed {
        logic              status;
        logic [PAGE_W-1:0] first_page;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FETCH,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic step;
        logic hit;
        logic pass_next;
        logic fail;
        logic mark_rd;
        logic mark_wr;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_free;
        logic cnt_zero;
        logic cur_ge_limit;
        logic bit_free;
        logic run_hit;
        logic word_end;
        logic pass2;
        logic last_word;
    } dp_stat_t;

endpackage

// ----- rtl/bpa_ctrl.sv -----
// controller state machine for the bitmap page allocator
module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  bpa_pkg::dp_stat_t stat,
    output bpa_pkg::ctrl_cmd_t cmd
);

    bpa_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bpa_pkg::S_START;
                end
            end
            bpa_pkg::S_START:
            begin
                if (stat.cnt_zero)
                begin
                    cmd.fail   = !stat.is_free;
                    state_next = bpa_pkg::S_RESP;
                end
                else if (stat.is_free)
                    state_next = bpa_pkg::S_MARK_RD;
                else
                    state_next = bpa_pkg::S_FETCH;
            end
            bpa_pkg::S_FETCH, bpa_pkg::S_SCAN:
            begin
                if (stat.cur_ge_limit)
                begin
                    // end of a pass: wrap to page 0 once, then give up
                    if (stat.pass2)
                    begin
                        cmd.fail   = 1'b1;
                        state_next = bpa_pkg::S_RESP;
                    end
                    else
                    begin
                        cmd.pass_next = 1'b1;
                        state_next    = bpa_pkg::S_FETCH;
                    end
                end
                else if (state_reg == bpa_pkg::S_FETCH)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = bpa_pkg::S_SCAN;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.bit_free && stat.run_hit)
                    begin
                        cmd.hit    = 1'b1;
                        state_next = bpa_pkg::S_MARK_RD;
                    end
                    else if (stat.word_end)
                        state_next = bpa_pkg::S_FETCH;
                end
            end
            bpa_pkg::S_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = bpa_pkg::S_MARK_WR;
            end
            bpa_pkg::S_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                if (stat.last_word)
                    state_next = bpa_pkg::S_RESP;
                else
                    state_next = bpa_pkg::S_MARK_RD;
            end
            bpa_pkg::S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall  = (state_reg != bpa_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/bpa_datapath.sv -----
// bitmap store, cursor, scan counters and range marking for the page allocator
module bpa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bpa_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  bpa_pkg::in_beat_t             in_data,
    output bpa_pkg::out_beat_t            out_data,
    input  bpa_pkg::ctrl_cmd_t            cmd,
    output bpa_pkg::dp_stat_t             stat
);

    localparam int CW = bpa_pkg::COUNT_W;
    localparam int OW = bpa_pkg::OFF_W;
    localparam int RW = bpa_pkg::ROW_W;
    localparam int PW = bpa_pkg::PAGE_W;
    localparam logic [CW-1:0] MAX_C = CW'(bpa_pkg::MAX_PAGES);

    logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::ROWS];
    logic [bpa_pkg::ROWS-1:0]      row_valid_reg;
    logic [bpa_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    logic [CW-1:0] total_reg;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] old_reg;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] run_reg, run_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] plimit_reg, plimit_next;
    logic          cmd_reg;
    logic          pass2_reg, pass2_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [RW-1:0] wptr_reg, wptr_next;
    logic          res_status_reg, res_status_next;
    logic [PW-1:0] res_first_reg, res_first_next;
    bpa_pkg::out_beat_t out_reg;

    logic [bpa_pkg::WORD_BITS-1:0] word;
    logic [bpa_pkg::WORD_BITS-1:0] mask;
    logic [bpa_pkg::WORD_BITS-1:0] wr_word;
    logic [CW-1:0]                 limit;
    logic [CW:0]                   free_end;
    logic [CW-1:0]                 free_hi;
    logic [CW-1:0]                 hi_m1;
    logic [CW-1:0]                 cur_p1;
    logic [CW-1:0]                 run_start;
    logic [OW-1:0]                 start_off;
    logic [OW:0]                   end_off;
    logic [RW-1:0]                 rd_addr;
    logic                          rd_en;

    // rows never written read as the reset pattern: every page used
    assign word = rd_valid_reg ? rd_data_reg : '1;

    assign limit    = (total_reg > MAX_C) ? MAX_C : total_reg;
    assign free_end = {1'b0, CW'(in_data.page_index)} + {1'b0, in_data.page_count};
    assign free_hi  = (free_end > {1'b0, MAX_C}) ? MAX_C : free_end[CW-1:0];
    assign hi_m1    = hi_reg - CW'(1);
    assign cur_p1   = cur_reg + CW'(1);
    assign run_start = cur_p1 - cnt_reg;

    assign rd_en   = cmd.fetch || cmd.mark_rd;
    assign rd_addr = cmd.fetch ? cur_reg[OW+RW-1:OW] : wptr_reg;

    // bits of the current row that fall inside [lo, hi)
    always_comb
    begin
        start_off = (wptr_reg == lo_reg[OW+RW-1:OW]) ? lo_reg[OW-1:0] : '0;
        if (wptr_reg == hi_m1[OW+RW-1:OW])
            end_off = {1'b0, hi_m1[OW-1:0]} + (OW+1)'(1);
        else
            end_off = (OW+1)'(bpa_pkg::WORD_BITS);
        for (int j = 0; j < bpa_pkg::WORD_BITS; j++)
            mask[j] = ((OW+1)'(j) >= {1'b0, start_off}) && ((OW+1)'(j) < end_off);
        if (cmd_reg == bpa_pkg::CMD_FREE)
            wr_word = word & ~mask;
        else
            wr_word = word | mask;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_wr)
            mem[wptr_reg] <= wr_word;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            total_reg     <= MAX_C;
            cursor_reg    <= '0;
        end
        else
        begin
            if (cmd.mark_wr)
                row_valid_reg[wptr_reg] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= row_valid_reg[rd_addr];
            if (cfg_wr_en)
                total_reg <= cfg_wr_data;
            cursor_reg <= cursor_next;
        end
    end

    always_comb
    begin
        cursor_next     = cursor_reg;
        cur_next        = cur_reg;
        run_next        = run_reg;
        plimit_next     = plimit_reg;
        pass2_next      = pass2_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        wptr_next       = wptr_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        if (cmd.load)
        begin
            cur_next        = cursor_reg;
            run_next        = '0;
            plimit_next     = limit;
            pass2_next      = 1'b0;
            lo_next         = CW'(in_data.page_index);
            hi_next         = free_hi;
            wptr_next       = in_data.page_index[OW+RW-1:OW];
            res_status_next = bpa_pkg::STATUS_OK;
            res_first_next  = '0;
        end
        if (cmd.step)
        begin
            cur_next = cur_p1;
            run_next = stat.bit_free ? run_reg + CW'(1) : '0;
        end
        if (cmd.hit)
        begin
            lo_next        = run_start;
            hi_next        = cur_p1;
            wptr_next      = run_start[OW+RW-1:OW];
            cursor_next    = cur_p1;
            res_first_next = run_start[PW-1:0];
        end
        if (cmd.pass_next)
        begin
            cur_next    = '0;
            run_next    = '0;
            plimit_next = old_reg;
            pass2_next  = 1'b1;
        end
        if (cmd.fail)
        begin
            res_status_next = bpa_pkg::STATUS_FAIL;
            res_first_next  = '0;
        end
        if (cmd.mark_wr)
            wptr_next = wptr_reg + RW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            old_reg <= cursor_reg;
            cnt_reg <= in_data.page_count;
            cmd_reg <= in_data.cmd;
        end
        cur_reg        <= cur_next;
        run_reg        <= run_next;
        plimit_reg     <= plimit_next;
        pass2_reg      <= pass2_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        wptr_reg       <= wptr_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        if (cmd.out_load)
        begin
            out_reg.status     <= res_status_reg;
            out_reg.first_page <= res_first_reg;
        end
    end

    assign out_data = out_reg;

    assign stat.is_free      = (cmd_reg == bpa_pkg::CMD_FREE);
    assign stat.cnt_zero     = (cnt_reg == '0);
    assign stat.cur_ge_limit = (cur_reg >= plimit_reg);
    assign stat.bit_free     = !word[cur_reg[OW-1:0]];
    assign stat.run_hit      = (run_reg + CW'(1) == cnt_reg);
    assign stat.word_end     = (cur_reg[OW-1:0] == '1);
    assign stat.pass2        = pass2_reg;
    assign stat.last_word    = (wptr_reg == hi_m1[OW+RW-1:OW]);

endmodule

// ----- rtl/bitmap_page_allocator_unit.sv -----
// top level of the next-fit bitmap page allocator
//
// channel   direction  handshake               payload
// cfg       in         cfg_wr_en               cfg_wr_data (total_pages)
// in        in         in_valid / in_stall     in_data (cmd, page_index, page_count)
// out       out        out_valid / out_stall   out_data (status, first_page)
//
// allocate: load and start, then scan page by page, fetching each 64-page row and ending
// a pass at the limit (wrap once), then a row read and a row write per row marked, then the result
// free: load and start, then a read-modify-write per 64-page row touched, then the result
// reset: no clearing pass, per-row valid bits make unwritten rows read as all used
// a result waiting on out_stall does not block the next input beat
module bitmap_page_allocator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bpa_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  bpa_pkg::in_beat_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output bpa_pkg::out_beat_t          out_data
);

    bpa_pkg::ctrl_cmd_t cmd;
    bpa_pkg::dp_stat_t  stat;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpa_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_data    (out_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
